// ===== hdl/sfd_pkg.sv =====
// shared types, constants and the crc-8 byte step for the stuffed frame deframer
// no dependencies
package sfd_pkg;

  localparam logic [7:0] START_BYTE_RESET    = 8'h1A;
  localparam logic       LENGTH_ADJUST_RESET = 1'b1;
  localparam logic [7:0] CRC_INIT            = 8'hFF;
  localparam logic [7:0] CRC_POLY            = 8'h31;
  localparam logic [7:0] CRC_MSB             = 8'h80;

  // configuration register indexes
  localparam logic REG_START_BYTE    = 1'b0;
  localparam logic REG_LENGTH_ADJUST = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_CRC_GOOD  = 2'd1;
  localparam logic [1:0] KIND_CRC_ERROR = 2'd2;
  localparam logic [1:0] KIND_RESTART   = 2'd3;

  // classified byte handed from front to back
  typedef struct packed {
    logic       is_open;   // start followed by length byte
    logic [7:0] value;     // raw byte (literal byte or raw length byte)
    logic [7:0] length;    // adjusted length, used when is_open
  } sfd_token_t;

  // one byte through crc-8, msb first, no final xor
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 8'd0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/sfd_front.sv =====
// front end: holds the configuration registers, unstuffs start bytes and
// classifies each received byte into a token; uses sfd_pkg
module sfd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output logic              tok_valid,
  output sfd_pkg::sfd_token_t tok
);
  import sfd_pkg::*;

  logic [7:0] start_byte;
  logic       length_adjust;
  logic       prev_was_start;
  logic       is_start;

  assign is_start = (rx_byte == start_byte);

  always_comb begin
    tok.value  = rx_byte;
    tok.length = (length_adjust && (rx_byte > start_byte)) ? rx_byte - 8'd1 : rx_byte;
    tok.is_open = prev_was_start && !is_start;
    // doubled start is a literal; a lone start only arms the escape
    if (prev_was_start) begin
      tok_valid = accept;
    end else begin
      tok_valid = accept && !is_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte     <= START_BYTE_RESET;
      length_adjust  <= LENGTH_ADJUST_RESET;
      prev_was_start <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_START_BYTE:    start_byte    <= cfg_data;
          REG_LENGTH_ADJUST: length_adjust <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        prev_was_start <= prev_was_start ? 1'b0 : is_start;
      end
    end
  end

endmodule

// ===== hdl/sfd_queue.sv =====
// small token queue between front and back ends
// uses sfd_pkg for the token type
module sfd_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  sfd_pkg::sfd_token_t wr_tok,
  output logic                full,
  input  logic                rd,
  output logic                avail,
  output sfd_pkg::sfd_token_t rd_tok
);
  import sfd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sfd_token_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_FULL);
  assign avail  = (count != '0);
  assign rd_tok = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + CNT_W'(1);
      end else if (rd && !wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/sfd_back.sv =====
// back end: frame state, length count and running crc, plus the result register
// uses sfd_pkg for the token type, kinds and crc step
module sfd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                tok_avail,
  input  sfd_pkg::sfd_token_t tok,
  output logic                tok_take,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          kind,
  output logic [7:0]          data_byte
);
  import sfd_pkg::*;

  logic       frame_open;
  logic [7:0] expected_length;
  logic [7:0] payload_count;
  logic [7:0] running_crc;
  logic       out_valid;

  logic       res_valid;
  logic [1:0] res_kind;
  logic [7:0] res_data;
  logic       frame_open_next;
  logic [7:0] expected_length_next;
  logic [7:0] payload_count_next;
  logic [7:0] running_crc_next;

  assign tok_take = tok_avail && (!out_valid || pop);
  assign empty    = !out_valid;

  always_comb begin
    res_valid            = 1'b0;
    res_kind             = KIND_PAYLOAD;
    res_data             = 8'd0;
    frame_open_next      = frame_open;
    expected_length_next = expected_length;
    payload_count_next   = payload_count;
    running_crc_next     = running_crc;
    if (tok.is_open) begin
      res_valid            = frame_open;
      res_kind             = KIND_RESTART;
      frame_open_next      = 1'b1;
      expected_length_next = tok.length;
      payload_count_next   = 8'd0;
      running_crc_next     = crc8_step(CRC_INIT, tok.value);
    end else if (frame_open) begin
      res_valid = 1'b1;
      if (payload_count == expected_length) begin
        // crc byte closes the frame
        frame_open_next = 1'b0;
        res_kind = (tok.value == running_crc) ? KIND_CRC_GOOD : KIND_CRC_ERROR;
      end else begin
        res_data           = tok.value;
        running_crc_next   = crc8_step(running_crc, tok.value);
        payload_count_next = payload_count + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open      <= 1'b0;
      expected_length <= 8'd0;
      payload_count   <= 8'd0;
      running_crc     <= CRC_INIT;
      out_valid       <= 1'b0;
    end else begin
      if (tok_take) begin
        frame_open      <= frame_open_next;
        expected_length <= expected_length_next;
        payload_count   <= payload_count_next;
        running_crc     <= running_crc_next;
        out_valid       <= res_valid;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_take && res_valid) begin
      kind      <= res_kind;
      data_byte <= res_data;
    end
  end

endmodule

// ===== hdl/stuffed_frame_deframer_crc8_core.sv =====
// stuffed frame deframer with crc-8 check, top level
// path: the front end writes the token of an accepted byte into the queue, and the back end
// takes it from there into the result register once that register is empty or being popped
// throughput: one byte per cycle while full is low; the back end holds while a result waits
// reset: rst clears frame state, queue and result register, restores register defaults
// depends on sfd_pkg, sfd_front, sfd_queue, sfd_back
module stuffed_frame_deframer_crc8_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind,
  output logic [7:0] data_byte
);
  import sfd_pkg::*;

  logic       accept;
  logic       front_valid;
  sfd_token_t front_tok;
  logic       q_avail;
  sfd_token_t q_tok;
  logic       back_take;

  assign accept = push && !full;

  sfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .tok_valid (front_valid),
    .tok       (front_tok)
  );

  sfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (front_valid),
    .wr_tok (front_tok),
    .full   (full),
    .rd     (back_take),
    .avail  (q_avail),
    .rd_tok (q_tok)
  );

  sfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_avail (q_avail),
    .tok       (q_tok),
    .tok_take  (back_take),
    .empty     (empty),
    .pop       (pop),
    .kind      (kind),
    .data_byte (data_byte)
  );

endmodule
